>>> design/mcld_pkg.sv
// mcld_pkg: shared constants and types for the monitor command line decoder
// argument limit, parse phase codes, command kinds, character codes, echo field masks and the line summary struct
// no dependencies
package mcld_pkg;

  localparam int MaxArgs = 4;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_ARGS   = 3'd3;
  localparam logic [2:0] PH_SINGLE = 3'd4;
  localparam logic [2:0] PH_LONG   = 3'd5;
  localparam logic [2:0] PH_BADARG = 3'd6;

  localparam logic [2:0] KIND_NOP     = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_WRITE   = 3'd2;
  localparam logic [2:0] KIND_ECHOOFF = 3'd3;
  localparam logic [2:0] KIND_ECHOON  = 3'd4;
  localparam logic [2:0] KIND_HELP    = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;

  localparam logic [2:0] LINK_MASK = 3'h7;
  localparam logic [7:0] DEST_MASK = 8'hFF;
  localparam logic [3:0] PORT_MASK = 4'hF;

  // line state as seen after the end-of-line beat has been parsed
  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic        cnt0;
    logic        cnt1;
    logic        cnt2;
    logic        cnt3;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [31:0] arg2;
  } line_t;

endpackage

>>> design/mcld_parser.sv
// mcld_parser: per-character line parser with hex argument collection
// holds phase, command characters, argument store and hex accumulator
// depends on mcld_pkg
module mcld_parser #(
  parameter int MaxArgs = mcld_pkg::MaxArgs
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        char_i,
  output logic              eol_o,
  output mcld_pkg::line_t   line_o
);

  localparam int CW = $clog2(MaxArgs + 1);
  localparam int IW = $clog2(MaxArgs);

  logic [2:0]    phase_q, phase_d, phase_post;
  logic [7:0]    c0_q, c0_d, c1_q, c1_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   accum_q, accum_d;
  logic          seen_q, seen_d;
  logic          store_en;
  logic [31:0]   args_q [MaxArgs];
  logic          eol, blank, is_hex;
  logic [3:0]    nib;

  assign eol = (char_i == mcld_pkg::CHAR_NUL) || (char_i == mcld_pkg::CHAR_LF) ||
               (char_i == mcld_pkg::CHAR_CR);
  assign blank = eol || (char_i == mcld_pkg::CHAR_SPACE) || (char_i == mcld_pkg::CHAR_TAB);

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (char_i >= "0" && char_i <= "9") begin
      nib = 4'(char_i - "0");
    end else if (char_i >= "A" && char_i <= "F") begin
      nib = 4'(char_i - "A" + 8'd10);
    end else if (char_i >= "a" && char_i <= "f") begin
      nib = 4'(char_i - "a" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    c0_d     = c0_q;
    c1_d     = c1_q;
    count_d  = count_q;
    accum_d  = accum_q;
    seen_d   = seen_q;
    store_en = 1'b0;
    unique case (phase_q)
      mcld_pkg::PH_START: begin
        c0_d = 8'd0;
        if (!blank) begin
          c0_d    = char_i;
          phase_d = mcld_pkg::PH_FIRST;
        end
      end
      mcld_pkg::PH_FIRST: begin
        if (!blank) begin
          c1_d    = char_i;
          phase_d = mcld_pkg::PH_SECOND;
        end else begin
          phase_d = mcld_pkg::PH_SINGLE;
        end
      end
      mcld_pkg::PH_SECOND: begin
        if (blank) begin
          count_d = '0;
          accum_d = 32'd0;
          seen_d  = 1'b0;
          phase_d = mcld_pkg::PH_ARGS;
        end else begin
          phase_d = mcld_pkg::PH_LONG;
        end
      end
      mcld_pkg::PH_ARGS: begin
        if (blank) begin
          if (seen_q && (count_q < CW'(MaxArgs))) begin
            store_en = 1'b1;
            count_d  = count_q + CW'(1);
            accum_d  = 32'd0;
            seen_d   = 1'b0;
          end
        end else if (is_hex) begin
          accum_d = {accum_q[27:0], nib};
          seen_d  = 1'b1;
        end else begin
          phase_d = mcld_pkg::PH_BADARG;
        end
      end
      default: begin
      end
    endcase
    phase_post = phase_d;
    if (eol) begin
      phase_d = mcld_pkg::PH_START;
    end
  end

  // arguments read after this beat, including one stored on this beat
  always_comb begin
    line_o.phase = phase_post;
    line_o.c0    = c0_d;
    line_o.c1    = c1_d;
    line_o.cnt0  = (count_d == CW'(0));
    line_o.cnt1  = (count_d == CW'(1));
    line_o.cnt2  = (count_d == CW'(2));
    line_o.cnt3  = (count_d == CW'(3));
    line_o.arg0  = (store_en && count_q == CW'(0)) ? accum_q : args_q[0];
    line_o.arg1  = (store_en && count_q == CW'(1)) ? accum_q : args_q[1];
    line_o.arg2  = (store_en && count_q == CW'(2)) ? accum_q : args_q[2];
  end

  assign eol_o = eol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mcld_pkg::PH_START;
      c0_q    <= 8'd0;
      c1_q    <= 8'd0;
      count_q <= '0;
      accum_q <= 32'd0;
      seen_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      count_q <= count_d;
      accum_q <= accum_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && store_en) begin
      args_q[count_q[IW-1:0]] <= accum_q;
    end
  end

endmodule

>>> design/mcld_decoder.sv
// mcld_decoder: end-of-line command decode and echo settings
// turns the parsed line into a command and updates the echo registers
// depends on mcld_pkg
module mcld_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  mcld_pkg::line_t line_i,
  output logic [2:0]      kind_o,
  output logic [1:0]      size_o,
  output logic [31:0]     addr_o,
  output logic [31:0]     value_o,
  output logic            echo_on_o,
  output logic [2:0]      link_o,
  output logic [7:0]      dest_o,
  output logic [3:0]      port_o
);

  logic       echo_q, echo_d;
  logic [2:0] link_q, link_d;
  logic [7:0] dest_q, dest_d;
  logic [3:0] port_q, port_d;
  logic       sz_ok, is_r, is_w, is_e;
  logic [1:0] sz;

  always_comb begin
    sz_ok = 1'b1;
    sz    = 2'd0;
    unique case (line_i.c1)
      "1":     sz = 2'd0;
      "2":     sz = 2'd1;
      "4":     sz = 2'd2;
      default: sz_ok = 1'b0;
    endcase
  end

  assign is_r = (line_i.c0 == "r") || (line_i.c0 == "R");
  assign is_w = (line_i.c0 == "w") || (line_i.c0 == "W");
  assign is_e = ((line_i.c0 == "e") || (line_i.c0 == "E")) &&
                ((line_i.c1 == "0") || (line_i.c1 == "1"));

  always_comb begin
    kind_o  = mcld_pkg::KIND_ERROR;
    size_o  = 2'd0;
    addr_o  = 32'd0;
    value_o = 32'd0;
    echo_d  = echo_q;
    link_d  = link_q;
    dest_d  = dest_q;
    port_d  = port_q;
    if (line_i.phase == mcld_pkg::PH_START) begin
      kind_o = mcld_pkg::KIND_NOP;
    end else if (line_i.phase == mcld_pkg::PH_BADARG) begin
      kind_o = mcld_pkg::KIND_ERROR;
    end else if (line_i.phase != mcld_pkg::PH_ARGS) begin
      kind_o = (line_i.c0 == mcld_pkg::CHAR_QUERY) ? mcld_pkg::KIND_HELP
                                                   : mcld_pkg::KIND_ERROR;
    end else if (is_r && sz_ok) begin
      if (line_i.cnt1) begin
        kind_o = mcld_pkg::KIND_READ;
        size_o = sz;
        addr_o = line_i.arg0;
      end
    end else if (is_w && sz_ok) begin
      if (line_i.cnt2) begin
        kind_o  = mcld_pkg::KIND_WRITE;
        size_o  = sz;
        addr_o  = line_i.arg0;
        value_o = line_i.arg1;
      end
    end else if (is_e) begin
      if (line_i.c1 == "0") begin
        kind_o = mcld_pkg::KIND_ECHOOFF;
        echo_d = 1'b0;
      end else if (line_i.cnt0 || line_i.cnt3) begin
        kind_o = mcld_pkg::KIND_ECHOON;
        echo_d = 1'b1;
        if (line_i.cnt3) begin
          link_d = line_i.arg0[2:0] & mcld_pkg::LINK_MASK;
          dest_d = line_i.arg1[7:0] & mcld_pkg::DEST_MASK;
          port_d = line_i.arg2[3:0] & mcld_pkg::PORT_MASK;
        end
      end
    end else if (line_i.c0 == mcld_pkg::CHAR_QUERY) begin
      kind_o = mcld_pkg::KIND_HELP;
    end
  end

  assign echo_on_o = echo_d;
  assign link_o    = link_d;
  assign dest_o    = dest_d;
  assign port_o    = port_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b0;
      link_q <= 3'd0;
      dest_q <= 8'd0;
      port_q <= 4'd0;
    end else if (upd_i) begin
      echo_q <= echo_d;
      link_q <= link_d;
      dest_q <= dest_d;
      port_q <= port_d;
    end
  end

endmodule

>>> design/monitor_command_line_decoder.sv
// monitor_command_line_decoder: top level of the monitor command line decoder
// input register, parser, decoder and result register
// depends on mcld_pkg, mcld_parser, mcld_decoder
//
//   channel  | signals                        | beat
//   ---------+--------------------------------+------------------------------
//   input    | in_valid_i/in_ready_o, char_in | one character
//   output   | out_valid_o/out_ready_i, cmd   | one command per end of line
//
// one character per clock sustained while no end-of-line character waits; a character
// is held in the input register and, if it ends the line, the command is written into
// the result register as that character leaves the input register
// the parser advances per character, the echo settings and result register per line;
// only an end-of-line character waits while the result register is still full
// reset clears parser state, echo settings and both valid flags
module monitor_command_line_decoder #(
  parameter int MaxArgs = mcld_pkg::MaxArgs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  command_kind_o,
  output logic [1:0]  access_size_o,
  output logic [31:0] bus_address_o,
  output logic [31:0] write_value_o,
  output logic        echo_on_o,
  output logic [2:0]  echo_link_o,
  output logic [7:0]  echo_dest_o,
  output logic [3:0]  echo_dst_port_o
);

  logic            in_valid_q;
  logic [7:0]      char_q;
  logic            out_valid_q;
  logic            eol, adv, out_free, emit;
  mcld_pkg::line_t line;
  logic [2:0]      kind_d, link_d;
  logic [1:0]      size_d;
  logic [31:0]     addr_d, value_d;
  logic            echo_d;
  logic [7:0]      dest_d;
  logic [3:0]      port_d;
  logic [2:0]      kind_q, link_q;
  logic [1:0]      size_q;
  logic [31:0]     addr_q, value_q;
  logic            echo_q;
  logic [7:0]      dest_q;
  logic [3:0]      port_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && (!eol || out_free);
  assign emit       = adv && eol;
  assign in_ready_o = !in_valid_q || adv;

  mcld_parser #(
    .MaxArgs(MaxArgs)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .char_i(char_q),
    .eol_o (eol),
    .line_o(line)
  );

  mcld_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (emit),
    .line_i   (line),
    .kind_o   (kind_d),
    .size_o   (size_d),
    .addr_o   (addr_d),
    .value_o  (value_d),
    .echo_on_o(echo_d),
    .link_o   (link_d),
    .dest_o   (dest_d),
    .port_o   (port_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
    if (emit) begin
      kind_q  <= kind_d;
      size_q  <= size_d;
      addr_q  <= addr_d;
      value_q <= value_d;
      echo_q  <= echo_d;
      link_q  <= link_d;
      dest_q  <= dest_d;
      port_q  <= port_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_kind_o  = kind_q;
  assign access_size_o   = size_q;
  assign bus_address_o   = addr_q;
  assign write_value_o   = value_q;
  assign echo_on_o       = echo_q;
  assign echo_link_o     = link_q;
  assign echo_dest_o     = dest_q;
  assign echo_dst_port_o = port_q;

endmodule
